[sv/fwp_pkg.sv]
`timescale 1ns / 1ps
package fwp_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SLOT_W = ADDR_W + 1;

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_POP     = 2'd1;
    localparam logic [1:0] OP_PROMOTE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    localparam logic [3:0] MOVED_MAX = 4'd15;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] popped_value;
        logic [3:0]         moved_count;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [31:0]       wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // store slot of a queue position, wrapped around the ring
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                  input logic [ADDR_W-1:0] pos);
        logic [SLOT_W-1:0] s;
        s = {1'b0, head} + {1'b0, pos};
        if (s >= SLOT_W'(DEPTH)) begin
            s = s - SLOT_W'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

[sv/fwp_mem.sv]
`timescale 1ns / 1ps
module fwp_mem (
    input  logic              i_clk,
    input  fwp_pkg::t_mem_req i_req,
    output logic [31:0]       o_rdata
);

    logic [31:0] r_store [fwp_pkg::DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_store[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_store[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/fwp_ctrl.sv]
`timescale 1ns / 1ps
module fwp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  fwp_pkg::t_item    i_item,
    output logic              o_strobe,
    output fwp_pkg::t_result  o_result,
    output fwp_pkg::t_mem_req o_req,
    input  logic [31:0]       i_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_POPRD  = 3'd1;
    localparam logic [2:0] S_PRHEAD = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_HDWR   = 3'd4;
    localparam logic [2:0] S_KEYWR  = 3'd5;

    localparam int AW = fwp_pkg::ADDR_W;
    localparam int CW = fwp_pkg::CNT_W;

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_pos, n_pos;
    logic [AW-1:0]    r_wpos, n_wpos;
    logic [CW-1:0]    r_moved, n_moved;
    logic [31:0]      r_key, n_key;
    logic [31:0]      r_hval, n_hval;
    logic             r_strobe, n_strobe;
    fwp_pkg::t_result r_result, n_result;
    fwp_pkg::t_mem_req req;
    logic [3:0]       moved_sat;

    always_comb begin
        if (32'(r_moved) > 32'(fwp_pkg::MOVED_MAX)) begin
            moved_sat = fwp_pkg::MOVED_MAX;
        end else begin
            moved_sat = 4'(r_moved);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_head   = r_head;
        n_pos    = r_pos;
        n_wpos   = r_wpos;
        n_moved  = r_moved;
        n_key    = r_key;
        n_hval   = r_hval;
        n_strobe = 1'b0;
        n_result = r_result;
        req.we    = 1'b0;
        req.waddr = fwp_pkg::slot_of(r_head, r_wpos);
        req.wdata = i_rdata;
        req.raddr = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_result = '0;
                    case (i_item.op)
                        fwp_pkg::OP_PUSH: begin
                            n_strobe = 1'b1;
                            if (r_count == CW'(fwp_pkg::DEPTH)) begin
                                n_result.status = fwp_pkg::ST_FULL;
                            end else begin
                                req.we    = 1'b1;
                                req.waddr = fwp_pkg::slot_of(r_head, AW'(r_count));
                                req.wdata = i_item.value;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        fwp_pkg::OP_POP: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_result.status = fwp_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_POPRD;
                            end
                        end
                        fwp_pkg::OP_PROMOTE: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_result.status = fwp_pkg::ST_EMPTY;
                            end else if (r_count == CW'(1)) begin
                                n_strobe = 1'b1;
                                n_result.status = fwp_pkg::ST_NOMATCH;
                            end else begin
                                n_key   = i_item.value;
                                n_pos   = AW'(r_count - CW'(1));
                                n_wpos  = AW'(r_count - CW'(1));
                                n_moved = '0;
                                n_state = S_PRHEAD;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_POPRD: begin
                n_strobe = 1'b1;
                n_result.popped_value = i_rdata;
                n_head  = fwp_pkg::slot_of(r_head, AW'(1));
                n_count = r_count - CW'(1);
                n_state = S_IDLE;
            end
            S_PRHEAD: begin
                n_hval    = i_rdata;
                req.raddr = fwp_pkg::slot_of(r_head, r_pos);
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                // pack non-matches toward the tail; write slot never trails the read
                if (i_rdata != r_key) begin
                    req.we = 1'b1;
                    n_wpos = r_wpos - AW'(1);
                end else begin
                    n_moved = r_moved + CW'(1);
                end
                if (r_pos == AW'(1)) begin
                    n_state = S_HDWR;
                end else begin
                    n_pos     = r_pos - AW'(1);
                    req.raddr = fwp_pkg::slot_of(r_head, r_pos - AW'(1));
                end
            end
            S_HDWR, S_KEYWR: begin
                req.we    = 1'b1;
                req.wdata = (r_state == S_HDWR) ? r_hval : r_key;
                if (r_wpos == '0) begin
                    n_strobe = 1'b1;
                    n_result.status = (r_moved == '0) ? fwp_pkg::ST_NOMATCH : fwp_pkg::ST_OK;
                    n_result.moved_count = moved_sat;
                    n_state = S_IDLE;
                end else begin
                    n_wpos  = r_wpos - AW'(1);
                    n_state = S_KEYWR;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_head   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_head   <= n_head;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_wpos   <= n_wpos;
        r_moved  <= n_moved;
        r_key    <= n_key;
        r_hval   <= n_hval;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;
    assign o_req    = req;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !busy)
        else $error("result beat while busy");

    a_push_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.op == fwp_pkg::OP_PUSH) |=> r_strobe)
        else $error("push result missing");

    a_pop_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.op == fwp_pkg::OP_POP && r_count != '0)
        |=> ##1 (r_strobe && r_result.status == fwp_pkg::ST_OK))
        else $error("pop result missing");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_wpos >= r_pos && r_pos != '0))
        else $error("scan write slot behind read slot");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(fwp_pkg::DEPTH) && start && !busy && i_item.op == fwp_pkg::OP_PUSH)
        |=> (r_count == CW'(fwp_pkg::DEPTH) && r_result.status == fwp_pkg::ST_FULL))
        else $error("push accepted on full queue");

endmodule

[sv/fifo_with_promote_to_head_core.sv]
`timescale 1ns / 1ps
// channel   ports                     handshake
// command   i_item (op, value)        start, taken when busy is low
// result    o_result (status, popped_value, moved_count)  o_strobe, one cycle
//
// Push, a rejected op and op code 3 answer in the cycle after start; a pop
// waits in state POPRD for the registered read port of the entry store.
// Promote does one read of the head, one read-modify-write per scanned entry
// below the head, then m + 1 fill writes for m matches, all through the
// single write port of the store.
// Reset (synchronous, active low) empties the queue; store contents are kept.
// Results cannot be stalled; a new command may start in the cycle of a result.
module fifo_with_promote_to_head_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  fwp_pkg::t_item   i_item,
    output logic             o_strobe,
    output fwp_pkg::t_result o_result
);

    fwp_pkg::t_mem_req req;
    logic [31:0]       rdata;

    fwp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .o_req    (req),
        .i_rdata  (rdata)
    );

    fwp_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (req),
        .o_rdata (rdata)
    );

endmodule

[tb/fwp_checker.sv]
`timescale 1ns / 1ps
module fwp_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  fwp_pkg::t_item   i_item,
    input  logic             i_strobe,
    input  fwp_pkg::t_result i_result,
    output int               o_fail_count,
    output int               o_pending
);
    import fwp_pkg::*;

    // queue contents in order, head first
    logic signed [31:0] held_values[$];
    t_result            awaited_results[$];
    int                 fail_count = 0;

    function automatic t_result apply_command(input t_item cmd);
        t_result            r;
        logic signed [31:0] reordered[$];
        int                 hit_count;
        int                 i;
        r = '0;
        case (cmd.op)
            OP_PUSH: begin
                if (held_values.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    held_values.push_back(cmd.value);
                end
            end
            OP_POP: begin
                if (held_values.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped_value = held_values.pop_front();
                end
            end
            OP_PROMOTE: begin
                if (held_values.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // collect hits tail first; the head is never tested
                    hit_count = 0;
                    for (i = held_values.size() - 1; i >= 1; i--) begin
                        if (held_values[i] == cmd.value) begin
                            reordered.push_back(held_values[i]);
                            hit_count++;
                        end
                    end
                    if (hit_count == 0) begin
                        r.status = ST_NOMATCH;
                    end else begin
                        reordered.push_back(held_values[0]);
                        for (i = 1; i < held_values.size(); i++) begin
                            if (held_values[i] != cmd.value) begin
                                reordered.push_back(held_values[i]);
                            end
                        end
                        held_values = reordered;
                        r.status = ST_OK;
                        r.moved_count = (hit_count > int'(MOVED_MAX)) ? MOVED_MAX
                                                                       : 4'(hit_count);
                    end
                end
            end
            default: begin
                r.status = ST_OK;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (i_rst_n) begin
            // compare first: a beat accepted now cannot answer at this edge
            if (i_strobe) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no command outstanding: status %0d popped %0d moved %0d",
                           i_result.status, i_result.popped_value, i_result.moved_count);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_result.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_result.status);
                        fail_count++;
                    end
                    if (i_result.popped_value !== want.popped_value) begin
                        $error("popped_value: expected %0d, actual %0d",
                               want.popped_value, i_result.popped_value);
                        fail_count++;
                    end
                    if (i_result.moved_count !== want.moved_count) begin
                        $error("moved_count: expected %0d, actual %0d",
                               want.moved_count, i_result.moved_count);
                        fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                awaited_results.push_back(apply_command(i_item));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= awaited_results.size();
    end

endmodule

[tb/tb_fifo_with_promote_to_head_core.sv]
`timescale 1ns / 1ps
module tb_fifo_with_promote_to_head_core;
    import fwp_pkg::*;

    localparam int         RANDOM_ITEMS = 1950;
    localparam int         CYCLE_LIMIT  = 500000;
    localparam int         DRAIN_CYCLES = 40;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_strobe;
    t_result o_result;
    int      fail_count;
    int      pending_results;
    int      cycle_count = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    fifo_with_promote_to_head_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    fwp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** fifo_with_promote_to_head_core: FAILED **");
            $finish;
        end
    end

    // hold the beat until the edge that takes it
    task automatic send_cmd(input logic [1:0] op, input logic signed [31:0] value);
        t_item cmd;
        cmd.op    = op;
        cmd.value = value;
        i_item <= cmd;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        logic signed [31:0] key_pool[4];
        logic               fill_phase;
        logic [1:0]         op;
        logic signed [31:0] value;
        int                 sent;
        int                 burst_len;
        int                 gap;
        int                 pick;
        int                 j;
        int                 k;

        start   <= 1'b0;
        i_item  <= '0;
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(OP_POP, 32'sd0);
        send_cmd(OP_PROMOTE, 32'sd0);
        send_cmd(OP_UNUSED, -32'sd1);
        send_cmd(OP_PUSH, 32'sh7FFFFFFF);
        send_cmd(OP_PROMOTE, 32'sh7FFFFFFF);
        send_cmd(OP_PUSH, 32'sh80000000);
        send_cmd(OP_PROMOTE, 32'sh80000001);
        send_cmd(OP_PROMOTE, 32'sh80000000);
        send_cmd(OP_POP, 32'sh7FFFFFFF);
        send_cmd(OP_POP, 32'sd0);
        for (j = 0; j < DEPTH; j++) begin
            send_cmd(OP_PUSH, -32'sd1);
        end
        send_cmd(OP_PUSH, 32'sd5);
        send_cmd(OP_PROMOTE, 32'shFFFFFFFE);
        send_cmd(OP_PROMOTE, -32'sd1);

        for (k = 0; k < 4; k++) begin
            key_pool[k] = $urandom;
        end
        fill_phase = 1'b0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst_len = $urandom_range(1, 24);
            if ($urandom_range(0, 2) == 0) begin
                fill_phase = !fill_phase;
            end
            for (k = 0; k < 4; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    key_pool[k] = $urandom;
                end
            end
            for (j = 0; j < burst_len && sent < RANDOM_ITEMS; j++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    op = OP_UNUSED;
                end else if (pick < 20) begin
                    op = OP_PROMOTE;
                end else if (pick < (fill_phase ? 70 : 40)) begin
                    op = OP_PUSH;
                end else begin
                    op = OP_POP;
                end
                // draw mostly from a small pool so promote finds matches
                if ($urandom_range(0, 9) < 7) begin
                    value = key_pool[$urandom_range(0, 3)];
                end else begin
                    value = $urandom;
                end
                send_cmd(op, value);
                if (op != OP_UNUSED) begin
                    sent++;
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                gap = 0;
            end else if ($urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 40);
            end else begin
                gap = $urandom_range(1, 5);
            end
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("** fifo_with_promote_to_head_core: PASSED **");
        end else begin
            $display("** fifo_with_promote_to_head_core: FAILED **");
        end
        $finish;
    end

endmodule
